>>> hw/rtl/box_side_hit_classifier_2d_defines.svh
// Assertion helpers for the box side hit classifier.
`ifndef BOX_SIDE_HIT_CLASSIFIER_2D_DEFINES_SVH
`define BOX_SIDE_HIT_CLASSIFIER_2D_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSHC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> hw/rtl/bshc_pkg.sv
package bshc_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		SIDE_FRONT_BACK = 2'd0,
		SIDE_LEFT_RIGHT = 2'd1,
		SIDE_NONE       = 2'd2
	} side_t;

	// three-valued sign of an exact product or difference
	typedef enum logic [1:0] {
		SGN_ZERO = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd2
	} sgn_t;

	function automatic sgn_t sgn_of(input logic is_zero, input logic is_neg);
		sgn_t s;
		if (is_zero) begin
			s = SGN_ZERO;
		end else if (is_neg) begin
			s = SGN_NEG;
		end else begin
			s = SGN_POS;
		end
		return s;
	endfunction

	function automatic sgn_t sgn_flip(input sgn_t a);
		sgn_t s;
		unique case (a)
			SGN_POS:  s = SGN_NEG;
			SGN_NEG:  s = SGN_POS;
			default:  s = SGN_ZERO;
		endcase
		return s;
	endfunction

endpackage

>>> hw/rtl/bshc_classify.sv
// Side classification, all relative to the box centre.
// Probe direction d = S - B; edge corners at (+-hw, +-hd).
// Probe-side signs reduce to U = dz*hw + dx*hd and V = dz*hw - dx*hd.
module bshc_classify #(
	parameter int COORD_WIDTH = bshc_pkg::COORD_WIDTH_DEF
) (
	input  logic signed [COORD_WIDTH-1:0] sphere_x,
	input  logic signed [COORD_WIDTH-1:0] sphere_z,
	input  logic signed [COORD_WIDTH-1:0] box_x,
	input  logic signed [COORD_WIDTH-1:0] box_z,
	input  logic        [COORD_WIDTH-2:0] half_width,
	input  logic        [COORD_WIDTH-2:0] half_depth,
	output bshc_pkg::side_t               side
);
	import bshc_pkg::*;

	localparam int DW = COORD_WIDTH + 1;     // offset width
	localparam int SW = 2 * COORD_WIDTH + 1; // product and sum width
	localparam int EW = COORD_WIDTH + 3;     // edge-side term width

	logic signed [DW-1:0] dx, dz;
	logic signed [COORD_WIDTH-1:0] hw_s, hd_s;
	logic signed [SW-1:0] prod_p, prod_q, sum_u, dif_v;
	logic signed [EW-1:0] dx_e, dz_e, hw_e, hd_e;
	logic signed [EW-1:0] t_front, t_back, t_left, t_right;
	logic hw_zero, hd_zero;
	sgn_t s_u, s_v;
	sgn_t fr_b, fr_e, bk_b, bk_e, lf_b, lf_e, rt_b, rt_e;
	logic hit_front, hit_back, hit_left, hit_right;

	assign dx   = DW'(sphere_x) - DW'(box_x);
	assign dz   = DW'(sphere_z) - DW'(box_z);
	assign hw_s = signed'({1'b0, half_width});
	assign hd_s = signed'({1'b0, half_depth});

	assign prod_p = SW'(dz) * SW'(hw_s);
	assign prod_q = SW'(dx) * SW'(hd_s);
	assign sum_u  = prod_p + prod_q;
	assign dif_v  = prod_p - prod_q;

	assign dx_e = EW'(dx);
	assign dz_e = EW'(dz);
	assign hw_e = EW'(hw_s);
	assign hd_e = EW'(hd_s);

	// probe end relative to each edge line (probe end is 2d)
	assign t_front = hd_e - (dz_e <<< 1);
	assign t_back  = (dz_e <<< 1) + hd_e;
	assign t_left  = (dx_e <<< 1) + hw_e;
	assign t_right = (dx_e <<< 1) - hw_e;

	assign hw_zero = (half_width == '0);
	assign hd_zero = (half_depth == '0);

	always_comb begin
		s_u = sgn_of(sum_u == '0, sum_u[SW-1]);
		s_v = sgn_of(dif_v == '0, dif_v[SW-1]);

		// edge orientation of the box centre and of the probe end
		fr_b = sgn_of(hw_zero || hd_zero, 1'b0);
		bk_b = sgn_of(hw_zero || hd_zero, 1'b1);
		lf_b = fr_b;
		rt_b = bk_b;
		fr_e = sgn_of(hw_zero || (t_front == '0), t_front[EW-1]);
		bk_e = sgn_flip(sgn_of(hw_zero || (t_back == '0), t_back[EW-1]));
		lf_e = sgn_of(hd_zero || (t_left == '0), t_left[EW-1]);
		rt_e = sgn_of(hd_zero || (t_right == '0), t_right[EW-1]);

		hit_front = (sgn_flip(s_u) != s_v) && (fr_b != fr_e);
		hit_back  = (sgn_flip(s_v) != s_u) && (bk_b != bk_e);
		hit_left  = (sgn_flip(s_v) != sgn_flip(s_u)) && (lf_b != lf_e);
		hit_right = (s_u != s_v) && (rt_b != rt_e);

		priority if (hit_front || hit_back) begin
			side = SIDE_FRONT_BACK;
		end else if (hit_left || hit_right) begin
			side = SIDE_LEFT_RIGHT;
		end else begin
			side = SIDE_NONE;
		end
	end

endmodule

>>> hw/rtl/box_side_hit_classifier_2d.sv
// Box side hit classifier, x-z plane. Each input word carries a sphere centre,
// a box centre and the box half extents in signed/unsigned Q8.8. A probe runs
// from the box centre to twice the sphere offset and is tested exactly against
// the four box edges; the result word gives the side struck: front/back (0),
// else left/right (1), else none (2, also for a sphere centred on the box).
// One word is accepted per clock unless the input stalls. A word taken is held
// in the input register, classified from it and stored in the result register,
// from which its result can be taken: an input register, one pass of two
// multipliers with an add and sign logic, and a result register.
// While a result waits on a stalled output the input register can still take
// one word; after that the input stalls until the result is taken. Throughput
// is one word a cycle whenever the output side keeps up.
module box_side_hit_classifier_2d #(
	parameter int COORD_WIDTH = bshc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] sphere_x,
	input  logic signed [COORD_WIDTH-1:0] sphere_z,
	input  logic signed [COORD_WIDTH-1:0] box_x,
	input  logic signed [COORD_WIDTH-1:0] box_z,
	input  logic        [COORD_WIDTH-2:0] half_width,
	input  logic        [COORD_WIDTH-2:0] half_depth,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    side
);
	import bshc_pkg::*;

	// stage 1: captured input word
	logic                          valid_s1;
	logic signed [COORD_WIDTH-1:0] sphere_x_s1, sphere_z_s1, box_x_s1, box_z_s1;
	logic        [COORD_WIDTH-2:0] half_width_s1, half_depth_s1;

	// stage 2: result word
	logic  valid_s2;
	side_t side_s2;
	side_t side_c;

	logic adv_s2;

	// result register frees when empty or being taken this cycle
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sphere_x_s1   <= sphere_x;
			sphere_z_s1   <= sphere_z;
			box_x_s1      <= box_x;
			box_z_s1      <= box_z;
			half_width_s1 <= half_width;
			half_depth_s1 <= half_depth;
		end
		if (adv_s2 && valid_s1) begin
			side_s2 <= side_c;
		end
	end

	bshc_classify #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_classify (
		.sphere_x   (sphere_x_s1),
		.sphere_z   (sphere_z_s1),
		.box_x      (box_x_s1),
		.box_z      (box_z_s1),
		.half_width (half_width_s1),
		.half_depth (half_depth_s1),
		.side       (side_c)
	);

	assign out_valid = valid_s2;
	assign side      = side_s2;

endmodule

>>> hw/rtl/bshc_checker.sv
`include "box_side_hit_classifier_2d_defines.svh"

module bshc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] side
);
	import bshc_pkg::*;

	// only the three defined side codes leave the block
	`BSHC_ASSERT_IMPLY(a_side_code, clk, arst_n, out_valid, side == SIDE_FRONT_BACK || side == SIDE_LEFT_RIGHT || side == SIDE_NONE)

	// a free or draining output never blocks the input
	`BSHC_ASSERT_IMPLY(a_ready_free, clk, arst_n, !out_valid || out_ready, in_ready)

	// an accepted word has a result showing once past the input and result registers
	`BSHC_ASSERT_NEXT(a_latency, clk, arst_n, in_valid && in_ready, ##1 out_valid)

	// a stalled result holds
	`BSHC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(side))

endmodule

bind box_side_hit_classifier_2d bshc_checker u_bshc_checker (.*);
